@@ src/four_level_page_table_engine_top_defines.svh @@
// ----------------------------------------------------------------------------
// Page table engine assertion macros
// Property wrappers used by the top level of the page table engine.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_ENGINE_TOP_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define FLPTE_ASSERT_IMP(label, clk, rst, a, c) label: assert property ( \
  @(posedge clk) disable iff (rst) (a) |-> (c)) else $error("flpte check failed");
`define FLPTE_ASSERT_NXT(label, clk, rst, a, c) label: assert property ( \
  @(posedge clk) disable iff (rst) (a) |=> (c)) else $error("flpte check failed");
`else
`define FLPTE_ASSERT_IMP(label, clk, rst, a, c)
`define FLPTE_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

@@ src/flpte_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table engine package
// Types, codes and helpers shared by the page table engine modules.
// ----------------------------------------------------------------------------
package flpte_pkg;

  localparam int TABLE_SLOTS_DEF   = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int FRAME_W           = 40;
  localparam int VA_W              = 48;
  localparam int PA_W              = 52;
  localparam int ENTRY_W           = 64;
  localparam int QUEUE_DEPTH       = 2;
  localparam logic [1:0] LVL_LEAF  = 2'd3;

  typedef enum logic [2:0] {
    CMD_MAP         = 3'd0,
    CMD_UNMAP       = 3'd1,
    CMD_TRANSLATE   = 3'd2,
    CMD_ADD_FLAGS   = 3'd3,
    CMD_WRITE_ENTRY = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    OP_MAP,
    OP_UNMAP,
    OP_XLATE,
    OP_ADDF,
    OP_WRITE,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_NOSLOT  = 2'd2,
    ST_OUTSIDE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_EVAL,
    BK_ZERO,
    BK_RESP
  } bk_state_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [47:0] virt_addr;
    logic [51:0] phys_addr;
    logic [63:0] page_flags;
    logic [5:0]  slot_select;
    logic [8:0]  entry_select;
    logic [63:0] raw_entry;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [51:0] phys_result;
    logic        mapped;
  } rsp_t;

  typedef struct packed {
    op_t  op;
    req_t req;
  } qent_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } bk_stat_t;

  function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                   input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0: idx = va[47:39];
      2'd1: idx = va[38:30];
      2'd2: idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

@@ src/four_level_page_table_engine_top.sv @@
// A request is dequeued, each table level is read and evaluated in turn, and the response is
// registered; write_entry and reserved commands finish without a walk.
// Each table allocated by map is zeroed one entry per cycle on the store port.
// One request is walked at a time.
// After reset all TABLE_SLOTS * 512 store entries are cleared before the first request.
// Reset is synchronous and active high; table_base_frame resets to zero.
`timescale 1ns / 1ps
`include "four_level_page_table_engine_top_defines.svh"
// ----------------------------------------------------------------------------
// Four-level page table engine
// Decoupled request queue and table walker over an on-chip page table store.
// ----------------------------------------------------------------------------
module four_level_page_table_engine_top import flpte_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [FRAME_W-1:0] cfg_wdata,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_t               rsp
);

  logic [FRAME_W-1:0] table_base_frame;
  logic               q_valid;
  qent_t              q_entry;
  logic               q_pop;
  logic [1:0]         q_count;
  bk_stat_t           bk_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_base_frame <= '0;
    end else if (cfg_we) begin
      table_base_frame <= cfg_wdata;
    end
  end

  flpte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .q_count   (q_count)
  );

  flpte_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .base      (table_base_frame),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .stat      (bk_stat)
  );

  `FLPTE_ASSERT_IMP(a_no_pop_in_clear, clk, rst, bk_stat.clearing, !q_pop)
  `FLPTE_ASSERT_NXT(a_pop_starts_walk, clk, rst, q_pop, bk_stat.busy)
  `FLPTE_ASSERT_IMP(a_mapped_done, clk, rst, rsp_valid && rsp.mapped, rsp.status == ST_DONE)
  `FLPTE_ASSERT_IMP(a_pop_needs_entry, clk, rst, q_pop, q_count != 2'd0)

endmodule

@@ src/flpte_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table engine front end
// Accepts requests, decodes the command and queues them for the walker.
// ----------------------------------------------------------------------------
module flpte_front import flpte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req,
  output logic       q_valid,
  output qent_t      q_entry,
  input  logic       q_pop,
  output logic [1:0] q_count
);

  qent_t      slots [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  op_t        op_dec;

  always_comb begin
    case (cmd_t'(req.command))
      CMD_MAP:         op_dec = OP_MAP;
      CMD_UNMAP:       op_dec = OP_UNMAP;
      CMD_TRANSLATE:   op_dec = OP_XLATE;
      CMD_ADD_FLAGS:   op_dec = OP_ADDF;
      CMD_WRITE_ENTRY: op_dec = OP_WRITE;
      default:         op_dec = OP_NONE;
    endcase
  end

  assign req_stall = (count == 2'(QUEUE_DEPTH));
  assign push      = req_valid && !req_stall;
  assign q_valid   = (count != 2'd0);
  assign q_entry   = slots[rd_ptr];
  assign q_count   = count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{op: op_dec, req: req};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

@@ src/flpte_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table engine walker
// Holds the table store and walks, allocates and updates entries per request.
// ----------------------------------------------------------------------------
module flpte_back import flpte_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [FRAME_W-1:0] base,
  input  logic               q_valid,
  input  qent_t              q_entry,
  output logic               q_pop,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_t               rsp,
  output bk_stat_t           stat
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int ADDR_W = SLOT_W + IDX_W;
  localparam int DEPTH  = TABLE_SLOTS * ENTRIES_PER_TABLE;
  localparam int SEL_W  = (SLOT_W > 6 ? SLOT_W : 6) + 1;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;

  bk_state_t state, state_next;
  qent_t cur, cur_next;
  logic [1:0] lvl, lvl_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic [SLOT_W-1:0] new_slot, new_slot_next;
  logic [SLOT_W:0] nfs, nfs_next;
  logic [IDX_W-1:0] zcnt, zcnt_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;
  rsp_t res, res_next;
  logic rsp_valid_next;
  rsp_t rsp_next;

  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] sel_addr;
  logic mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  logic ev_fin, ev_adv, ev_alloc, ev_wr;
  logic [ENTRY_W-1:0] ev_wdata;
  rsp_t ev_res;
  logic [SLOT_W-1:0] ev_slot;
  logic can_load;

  logic [ENTRY_W-1:0] e;
  logic [ENTRY_W-1:0] upper;
  logic [ENTRY_W-1:0] e_up;
  logic [FRAME_W-1:0] rel;
  logic rel_ok;
  logic [FRAME_W-1:0] link_frame;
  logic [SEL_W-1:0] sel_ext;
  logic sel_ok;
  logic nfs_full;

  assign e          = rd_data;
  assign upper      = {61'b0, cur.req.page_flags[2:1], 1'b0};
  assign e_up       = e | upper;
  assign rel        = e[51:12] - base;
  assign rel_ok     = rel < FRAME_W'(TABLE_SLOTS);
  assign link_frame = base + FRAME_W'(nfs[SLOT_W-1:0]);
  assign sel_ext    = SEL_W'(cur.req.slot_select);
  assign sel_ok     = sel_ext < SEL_W'(TABLE_SLOTS);
  assign sel_addr   = {sel_ext[SLOT_W-1:0], cur.req.entry_select};
  assign nfs_full   = nfs >= (SLOT_W+1)'(TABLE_SLOTS);
  assign rd_addr    = {slot, level_index(cur.req.virt_addr, lvl)};
  assign can_load   = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // Decision for the current level, or for requests that need no walk.
  always_comb begin
    ev_fin   = 1'b0;
    ev_adv   = 1'b0;
    ev_alloc = 1'b0;
    ev_wr    = 1'b0;
    ev_wdata = '0;
    ev_slot  = rel[SLOT_W-1:0];
    ev_res   = '{status: ST_DONE, phys_result: '0, mapped: 1'b0};
    if (state == BK_READ) begin
      if (cur.op == OP_WRITE) begin
        ev_fin = 1'b1;
        if (sel_ok) begin
          ev_wr    = 1'b1;
          ev_wdata = cur.req.raw_entry;
        end else begin
          ev_res.status = ST_OUTSIDE;
        end
      end else if (cur.op == OP_NONE) begin
        ev_fin = 1'b1;
      end
    end else begin
      case (cur.op)
        OP_MAP: begin
          if (lvl == LVL_LEAF) begin
            ev_wr    = 1'b1;
            ev_wdata = {12'b0, cur.req.phys_addr[51:12], 12'b0} |
                       cur.req.page_flags | 64'd1;
            ev_fin   = 1'b1;
          end else if (e[0]) begin
            if (rel_ok) begin
              ev_adv = 1'b1;
            end else begin
              ev_fin = 1'b1;
              ev_res.status = ST_OUTSIDE;
            end
          end else if (nfs_full) begin
            ev_fin = 1'b1;
            ev_res.status = ST_NOSLOT;
          end else begin
            ev_alloc = 1'b1;
            ev_wr    = 1'b1;
            ev_wdata = {12'b0, link_frame, 12'h007};
          end
        end
        OP_UNMAP: begin
          if (lvl == LVL_LEAF) begin
            ev_wr  = 1'b1;
            ev_fin = 1'b1;
          end else if (!e[0]) begin
            ev_fin = 1'b1;
            ev_res.status = ST_ABSENT;
          end else if (rel_ok) begin
            ev_adv = 1'b1;
          end else begin
            ev_fin = 1'b1;
            ev_res.status = ST_OUTSIDE;
          end
        end
        OP_XLATE: begin
          if (!e[0]) begin
            ev_fin = 1'b1;
            ev_res.status = ST_ABSENT;
          end else if (lvl == LVL_LEAF) begin
            ev_fin = 1'b1;
            ev_res.phys_result = {e[51:12], cur.req.virt_addr[11:0]};
            ev_res.mapped = 1'b1;
          end else if (lvl == 2'd1 && e[7]) begin
            ev_fin = 1'b1;
            ev_res.phys_result = {e[51:30], cur.req.virt_addr[29:0]};
            ev_res.mapped = 1'b1;
          end else if (lvl == 2'd2 && e[7]) begin
            ev_fin = 1'b1;
            ev_res.phys_result = {e[51:21], cur.req.virt_addr[20:0]};
            ev_res.mapped = 1'b1;
          end else if (rel_ok) begin
            ev_adv = 1'b1;
          end else begin
            ev_fin = 1'b1;
            ev_res.status = ST_OUTSIDE;
          end
        end
        OP_ADDF: begin
          if (!e[0]) begin
            ev_fin = 1'b1;
            ev_res.status = ST_ABSENT;
          end else if (lvl == LVL_LEAF) begin
            ev_wr    = 1'b1;
            ev_wdata = e | cur.req.page_flags;
            ev_fin   = 1'b1;
          end else if ((lvl == 2'd1 || lvl == 2'd2) && e[7]) begin
            ev_wr    = 1'b1;
            ev_wdata = e_up | cur.req.page_flags;
            ev_fin   = 1'b1;
          end else begin
            ev_wr    = 1'b1;
            ev_wdata = e_up;
            if (rel_ok) begin
              ev_adv = 1'b1;
            end else begin
              ev_fin = 1'b1;
              ev_res.status = ST_OUTSIDE;
            end
          end
        end
        default: begin
          ev_fin = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          state_next = BK_READ;
        end
      end
      BK_READ: begin
        state_next = ev_fin ? BK_RESP : BK_EVAL;
      end
      BK_EVAL: begin
        if (ev_fin) begin
          state_next = BK_RESP;
        end else if (ev_alloc) begin
          state_next = BK_ZERO;
        end else begin
          state_next = BK_READ;
        end
      end
      BK_ZERO: begin
        if (zcnt == IDX_W'(ENTRIES_PER_TABLE - 1)) begin
          state_next = BK_READ;
        end
      end
      BK_RESP: begin
        if (can_load) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cur_next       = cur;
    lvl_next       = lvl;
    slot_next      = slot;
    new_slot_next  = new_slot;
    nfs_next       = nfs;
    zcnt_next      = zcnt;
    clr_addr_next  = clr_addr;
    res_next       = res;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = rd_addr;
    mem_wdata      = ev_wdata;
    case (state)
      BK_CLEAR: begin
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        mem_wdata     = '0;
        clr_addr_next = clr_addr + 1'b1;
      end
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_next  = q_entry;
          lvl_next  = 2'd0;
          slot_next = '0;
        end
      end
      BK_READ: begin
        mem_we    = ev_wr;
        mem_waddr = sel_addr;
        if (ev_fin) begin
          res_next = ev_res;
        end
      end
      BK_EVAL: begin
        mem_we = ev_wr;
        if (ev_fin) begin
          res_next = ev_res;
        end
        if (ev_alloc) begin
          new_slot_next = nfs[SLOT_W-1:0];
          nfs_next      = nfs + 1'b1;
          zcnt_next     = '0;
        end
        if (ev_adv) begin
          slot_next = ev_slot;
          lvl_next  = lvl + 2'd1;
        end
      end
      BK_ZERO: begin
        mem_we    = 1'b1;
        mem_waddr = {new_slot, zcnt};
        mem_wdata = '0;
        zcnt_next = zcnt + 1'b1;
        if (zcnt == IDX_W'(ENTRIES_PER_TABLE - 1)) begin
          slot_next = new_slot;
          lvl_next  = lvl + 2'd1;
        end
      end
      BK_RESP: begin
        if (can_load) begin
          rsp_valid_next = 1'b1;
          rsp_next       = res;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_addr  <= '0;
      nfs       <= (SLOT_W+1)'(1);
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      nfs       <= nfs_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    lvl      <= lvl_next;
    slot     <= slot_next;
    new_slot <= new_slot_next;
    zcnt     <= zcnt_next;
    res      <= res_next;
    rsp      <= rsp_next;
  end

  assign stat = '{clearing: (state == BK_CLEAR), busy: (state != BK_IDLE)};

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table engine testbench
// Drives map, unmap, translate, add_flags and write_entry requests into the
// engine under random valid and stall pressure, predicts every response from
// a private copy of the table store and compares each one field by field.
// ----------------------------------------------------------------------------
module tb;
  import flpte_pkg::*;

  localparam int SLOTS = TABLE_SLOTS_DEF;
  localparam int LIMIT = 1000000;
  localparam logic [2:0] CMD_RESERVED_5 = 3'd5;
  localparam logic [2:0] CMD_RESERVED_7 = 3'd7;

  class pt_scoreboard;
    logic [63:0] store [SLOTS*ENTRIES_PER_TABLE];
    logic [39:0] base;
    int unsigned next_free;
    rsp_t expected_q[$];
    int errors;

    function new();
      foreach (store[i]) store[i] = '0;
      base = '0;
      next_free = 1;
      errors = 0;
    endfunction

    function int unsigned ix(int unsigned s, logic [8:0] i);
      return s * ENTRIES_PER_TABLE + i;
    endfunction

    function logic [8:0] lvl_idx(logic [47:0] va, int lv);
      return va[47-9*lv -: 9];
    endfunction

    function bit follow(logic [63:0] ent, inout int unsigned s);
      logic [39:0] rel;
      rel = ent[51:12] - base;
      if (rel >= SLOTS) return 0;
      s = 32'(rel);
      return 1;
    endfunction

    function status_t walk_map(logic [47:0] va, logic [51:0] pa, logic [63:0] fl);
      int unsigned s, ns, k;
      s = 0;
      for (int lv = 0; lv < 3; lv++) begin
        k = ix(s, lvl_idx(va, lv));
        if (store[k][0]) begin
          if (!follow(store[k], s)) return ST_OUTSIDE;
        end else begin
          if (next_free >= SLOTS) return ST_NOSLOT;
          ns = next_free;
          next_free++;
          for (int j = 0; j < ENTRIES_PER_TABLE; j++) store[ix(ns, 9'(j))] = '0;
          store[k] = {12'h0, 40'(base + ns), 12'h007};
          s = ns;
        end
      end
      store[ix(s, lvl_idx(va, 3))] = {12'h0, pa[51:12], 12'h0} | fl | 64'h1;
      return ST_DONE;
    endfunction

    function status_t walk_unmap(logic [47:0] va);
      int unsigned s, k;
      s = 0;
      for (int lv = 0; lv < 3; lv++) begin
        k = ix(s, lvl_idx(va, lv));
        if (!store[k][0]) return ST_ABSENT;
        if (!follow(store[k], s)) return ST_OUTSIDE;
      end
      store[ix(s, lvl_idx(va, 3))] = '0;
      return ST_DONE;
    endfunction

    function status_t walk_translate(logic [47:0] va, output logic [51:0] pa);
      int unsigned s, k;
      logic [63:0] ent;
      s = 0;
      pa = '0;
      for (int lv = 0; lv < 4; lv++) begin
        k = ix(s, lvl_idx(va, lv));
        ent = store[k];
        if (!ent[0]) return ST_ABSENT;
        if (lv == 3) begin
          pa = {ent[51:12], va[11:0]};
          return ST_DONE;
        end
        if (lv == 1 && ent[7]) begin
          pa = {ent[51:30], va[29:0]};
          return ST_DONE;
        end
        if (lv == 2 && ent[7]) begin
          pa = {ent[51:21], va[20:0]};
          return ST_DONE;
        end
        if (!follow(ent, s)) return ST_OUTSIDE;
      end
      return ST_DONE;
    endfunction

    function status_t walk_add_flags(logic [47:0] va, logic [63:0] fl);
      int unsigned s, k;
      logic [63:0] upper;
      s = 0;
      upper = fl & 64'h6;
      for (int lv = 0; lv < 4; lv++) begin
        k = ix(s, lvl_idx(va, lv));
        if (!store[k][0]) return ST_ABSENT;
        if (lv == 3) begin
          store[k] |= fl;
          return ST_DONE;
        end
        store[k] |= upper;
        if (lv > 0 && store[k][7]) begin
          store[k] |= fl;
          return ST_DONE;
        end
        if (!follow(store[k], s)) return ST_OUTSIDE;
      end
      return ST_DONE;
    endfunction

    function void note_request(req_t r);
      rsp_t x;
      logic [51:0] pa;
      x = '0;
      case (r.command)
        CMD_MAP: x.status = walk_map(r.virt_addr, r.phys_addr, r.page_flags);
        CMD_UNMAP: x.status = walk_unmap(r.virt_addr);
        CMD_TRANSLATE: begin
          x.status = walk_translate(r.virt_addr, pa);
          x.mapped = (x.status == ST_DONE);
          x.phys_result = x.mapped ? pa : '0;
        end
        CMD_ADD_FLAGS: x.status = walk_add_flags(r.virt_addr, r.page_flags);
        CMD_WRITE_ENTRY: begin
          if (r.slot_select >= SLOTS) x.status = ST_OUTSIDE;
          else store[ix(32'(r.slot_select), r.entry_select)] = r.raw_entry;
        end
        default: x.status = ST_DONE;
      endcase
      expected_q.push_back(x);
    endfunction

    function void check_response(rsp_t a);
      rsp_t x;
      if (expected_q.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
        return;
      end
      x = expected_q.pop_front();
      if (a.status !== x.status) begin
        $error("status expected %0d actual %0d", x.status, a.status);
        errors++;
      end
      if (a.phys_result !== x.phys_result) begin
        $error("phys_result expected %h actual %h", x.phys_result, a.phys_result);
        errors++;
      end
      if (a.mapped !== x.mapped) begin
        $error("mapped expected %0d actual %0d", x.mapped, a.mapped);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [FRAME_W-1:0] cfg_wdata = '0;
  logic req_valid = 0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 0;
  rsp_t rsp;

  pt_scoreboard sb = new();
  bit quiet = 0;
  bit hold_req = 0;
  int cycles = 0;
  int hold_cnt = 0;
  int burst_cnt = 0;

  four_level_page_table_engine_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(req);
      if (rsp_valid && !rsp_stall) sb.check_response(rsp);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      rsp_stall <= 1;
    end else if (hold_req) begin
      hold_req = 0;
      hold_cnt = 400;
      rsp_stall <= 1;
    end else if (quiet) begin
      rsp_stall <= 0;
    end else if (burst_cnt > 0) begin
      burst_cnt--;
    end else begin
      burst_cnt = $urandom_range(1, 16);
      rsp_stall <= 1'($urandom_range(0, 1));
    end
  end

  function req_t mk(logic [2:0] c, logic [47:0] va, logic [51:0] pa, logic [63:0] fl,
                    logic [5:0] sl, logic [8:0] en, logic [63:0] raw);
    req_t r;
    r.command = c;
    r.virt_addr = va;
    r.phys_addr = pa;
    r.page_flags = fl;
    r.slot_select = sl;
    r.entry_select = en;
    r.raw_entry = raw;
    return r;
  endfunction

  function logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function logic [47:0] rand_va();
    logic [63:0] v;
    v = rand64();
    if ($urandom_range(0, 9) == 0) return v[47:0];
    for (int lv = 0; lv < 3; lv++) begin
      case ($urandom_range(0, 2))
        0: v[47-9*lv -: 9] = 9'd0;
        1: v[47-9*lv -: 9] = 9'd1;
        default: v[47-9*lv -: 9] = 9'd511;
      endcase
    end
    return v[47:0];
  endfunction

  function req_t random_item();
    int r;
    logic [2:0] c;
    logic [47:0] va;
    logic [63:0] pa, fl, raw;
    logic [8:0] en;
    r = $urandom_range(0, 99);
    va = rand_va();
    pa = rand64();
    fl = ($urandom_range(0, 2) == 0) ? rand64() : 64'($urandom_range(0, 4095));
    en = $urandom_range(0, 1) ? va[47-9*$urandom_range(0, 3) -: 9] : 9'($urandom());
    case ($urandom_range(0, 2))
      0: raw = {12'h0, pa[51:12], 12'h081} | 64'($urandom_range(0, 6));
      1: raw = {12'h0, 40'(sb.base + $urandom_range(0, SLOTS + 3)), 12'h007};
      default: raw = rand64();
    endcase
    if (r < 30) c = CMD_MAP;
    else if (r < 55) c = CMD_TRANSLATE;
    else if (r < 70) c = CMD_UNMAP;
    else if (r < 85) c = CMD_ADD_FLAGS;
    else if (r < 97) c = CMD_WRITE_ENTRY;
    else c = 3'(CMD_RESERVED_5 + $urandom_range(0, 2));
    return mk(c, va, pa[51:0], fl, 6'($urandom()), en, raw);
  endfunction

  task send(req_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_valid <= 1;
    req <= r;
    do @(posedge clk); while (req_stall);
  endtask

  task drain();
    req_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task write_base(logic [39:0] v);
    drain();
    repeat (20) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.base = v;
  endtask

  task send_random(int n);
    for (int i = 0; i < n; i++) send(random_item());
  endtask

  initial begin
    logic [63:0] v;
    repeat (5) @(posedge clk);
    rst <= 0;
    write_base(40'h0);

    send(mk(CMD_TRANSLATE, 48'h0, 52'h0, 64'h0, 6'd0, 9'd0, 64'h0));
    send(mk(CMD_UNMAP, 48'h0, 52'h0, 64'h0, 6'd0, 9'd0, 64'h0));
    send(mk(CMD_ADD_FLAGS, 48'h0, 52'h0, 64'h6, 6'd0, 9'd0, 64'h0));
    send(mk(CMD_MAP, 48'h0, '1, 64'h0, 6'd0, 9'd0, 64'h0));
    send(mk(CMD_MAP, '1, 52'h0, '1, 6'd0, 9'd0, 64'h0));
    send(mk(CMD_TRANSLATE, 48'h0abc, 52'h0, 64'h0, 6'd0, 9'd0, 64'h0));
    send(mk(CMD_TRANSLATE, '1, 52'h0, 64'h0, 6'd0, 9'd0, 64'h0));
    send(mk(CMD_ADD_FLAGS, 48'h0, 52'h0, 64'h6, 6'd0, 9'd0, 64'h0));
    send(mk(CMD_UNMAP, 48'h0, 52'h0, 64'h0, 6'd0, 9'd0, 64'h0));
    send(mk(CMD_TRANSLATE, 48'h0, 52'h0, 64'h0, 6'd0, 9'd0, 64'h0));
    send(mk(CMD_WRITE_ENTRY, 48'h0, 52'h0, 64'h0, 6'd1, 9'd5, 64'h0000_0040_0000_0081));
    send(mk(CMD_TRANSLATE, {9'd0, 9'd5, 30'h1234_5678}, 52'h0, 64'h0, 6'd0, 9'd0, 64'h0));
    send(mk(CMD_WRITE_ENTRY, 48'h0, 52'h0, 64'h0, 6'd2, 9'd7, 64'h0000_0000_0060_0083));
    send(mk(CMD_TRANSLATE, {9'd0, 9'd0, 9'd7, 21'h1_2345}, 52'h0, 64'h0, 6'd0, 9'd0, 64'h0));
    send(mk(CMD_ADD_FLAGS, {9'd0, 9'd0, 9'd7, 21'h0}, 52'h0, 64'h8000_0000_0000_0010,
            6'd0, 9'd0, 64'h0));
    send(mk(CMD_ADD_FLAGS, {9'd0, 9'd5, 30'h0}, 52'h0, 64'h4, 6'd0, 9'd0, 64'h0));
    send(mk(CMD_WRITE_ENTRY, 48'h0, 52'h0, 64'h0, 6'd0, 9'd300, 64'h0000_0000_03e8_0001));
    send(mk(CMD_TRANSLATE, {9'd300, 39'h0}, 52'h0, 64'h0, 6'd0, 9'd0, 64'h0));
    send(mk(CMD_MAP, {9'd300, 39'h0}, 52'h0, 64'h0, 6'd0, 9'd0, 64'h0));
    send(mk(CMD_UNMAP, {9'd300, 39'h0}, 52'h0, 64'h0, 6'd0, 9'd0, 64'h0));
    send(mk(CMD_ADD_FLAGS, {9'd300, 39'h0}, 52'h0, 64'h6, 6'd0, 9'd0, 64'h0));
    send(mk(CMD_RESERVED_5, '1, '1, '1, '1, '1, '1));
    send(mk(CMD_RESERVED_7, 48'h0, 52'h0, 64'h0, 6'd0, 9'd0, 64'h0));
    send(mk(CMD_WRITE_ENTRY, 48'h0, 52'h0, 64'h0, 6'd63, 9'd511, '1));

    send_random(450);
    write_base('1);
    hold_req = 1;
    send_random(350);
    v = rand64();
    write_base(v[39:0]);
    send_random(300);
    write_base(40'h0);
    quiet = 1;
    send_random(300);
    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+src
src/flpte_pkg.sv
src/flpte_front.sv
src/flpte_back.sv
src/four_level_page_table_engine_top.sv
bench/tb.sv
